@@ rtl/wsfd_pkg.sv @@
`timescale 1ns / 1ps

package wsfd_pkg;

   localparam int MASK_BYTES = 4;
   localparam int KEY_IDX_W  = $clog2(MASK_BYTES);
   localparam int KEY_W      = 8 * MASK_BYTES;
   localparam int LEN_W      = 32;
   localparam int HDR_IDX_W  = 4;

   localparam logic [7:0] START_TEXT  = 8'h81;
   localparam logic [7:0] START_CLOSE = 8'h88;
   localparam logic [7:0] START_PING  = 8'h89;
   localparam logic [7:0] START_PONG  = 8'h8a;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   localparam logic [HDR_IDX_W-1:0] EXT16_BYTES = HDR_IDX_W'(2);
   localparam logic [HDR_IDX_W-1:0] EXT64_BYTES = HDR_IDX_W'(8);
   localparam logic [HDR_IDX_W-1:0] KEY_BYTES  = HDR_IDX_W'(MASK_BYTES);

   typedef struct packed {
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last_of_frame;
      logic [3:0] frame_opcode;
      logic       is_close;
      logic       bad_header;
   } result_type;

endpackage

@@ rtl/wsfd_frame_parser.sv @@
`timescale 1ns / 1ps

module wsfd_frame_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          stream_byte,
   output logic                result_valid,
   output wsfd_pkg::result_type result
);

   typedef enum logic [2:0] {
      PH_FIRST   = 3'd0,
      PH_SECOND  = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type                              phase_ff, phase_in;
   logic [wsfd_pkg::HDR_IDX_W-1:0]         header_index_ff, header_index_in;
   logic [wsfd_pkg::LEN_W-1:0]             payload_length_ff, payload_length_in;
   logic [wsfd_pkg::LEN_W-1:0]             payload_index_ff, payload_index_in;
   logic [wsfd_pkg::KEY_W-1:0]             mask_key_ff, mask_key_in;
   logic                                   mask_present_ff, mask_present_in;
   logic [3:0]                             opcode_held_ff, opcode_held_in;
   logic                                   close_held_ff, close_held_in;

   logic                                   length_done;
   logic                                   header_done;
   logic [wsfd_pkg::HDR_IDX_W-1:0]         header_dec;
   logic [wsfd_pkg::LEN_W-1:0]             index_inc;
   logic [wsfd_pkg::KEY_IDX_W-1:0]         key_sel;
   logic [7:0]                             key_byte;
   logic [6:0]                             len7;

   assign len7       = stream_byte[6:0];
   assign header_dec = header_index_ff - wsfd_pkg::HDR_IDX_W'(1);
   assign index_inc  = payload_index_ff + wsfd_pkg::LEN_W'(1);
   assign key_sel    = payload_index_ff[wsfd_pkg::KEY_IDX_W-1:0];

   // The first key byte received sits in the most significant position.
   assign key_byte = mask_key_ff[8 * (wsfd_pkg::MASK_BYTES - 1 - int'(key_sel)) +: 8];

   always_comb begin
      phase_in          = phase_ff;
      header_index_in   = header_index_ff;
      payload_length_in = payload_length_ff;
      payload_index_in  = payload_index_ff;
      mask_key_in       = mask_key_ff;
      mask_present_in   = mask_present_ff;
      opcode_held_in    = opcode_held_ff;
      close_held_in     = close_held_ff;
      length_done       = 1'b0;
      header_done       = 1'b0;
      result_valid      = 1'b0;
      result            = '0;

      unique case (phase_ff)
         PH_SECOND: begin
            mask_present_in = stream_byte[7];
            if (len7 == wsfd_pkg::LEN_CODE_16 || len7 == wsfd_pkg::LEN_CODE_64) begin
               header_index_in   = (len7 == wsfd_pkg::LEN_CODE_16) ?
                                   wsfd_pkg::EXT16_BYTES : wsfd_pkg::EXT64_BYTES;
               payload_length_in = '0;
               phase_in          = PH_EXTLEN;
            end else begin
               payload_length_in = wsfd_pkg::LEN_W'(len7);
               length_done       = 1'b1;
            end
         end
         PH_EXTLEN: begin
            payload_length_in = {payload_length_ff[wsfd_pkg::LEN_W-9:0], stream_byte};
            header_index_in   = header_dec;
            length_done       = (header_dec == '0);
         end
         PH_MASK: begin
            mask_key_in     = {mask_key_ff[wsfd_pkg::KEY_W-9:0], stream_byte};
            header_index_in = header_dec;
            header_done     = (header_dec == '0);
         end
         PH_PAYLOAD: begin
            payload_index_in     = index_inc;
            result_valid         = 1'b1;
            result.payload_byte  = mask_present_ff ? (stream_byte ^ key_byte) : stream_byte;
            result.has_byte      = 1'b1;
            result.last_of_frame = (index_inc == payload_length_ff);
            result.frame_opcode  = opcode_held_ff;
            result.is_close      = close_held_ff;
            if (index_inc == payload_length_ff) begin
               phase_in = PH_FIRST;
            end
         end
         default: begin
            if (stream_byte inside {wsfd_pkg::START_TEXT, wsfd_pkg::START_CLOSE,
                                    wsfd_pkg::START_PING, wsfd_pkg::START_PONG}) begin
               opcode_held_in  = stream_byte[3:0];
               close_held_in   = (stream_byte == wsfd_pkg::START_CLOSE);
               header_index_in = '0;
               phase_in        = PH_SECOND;
            end else begin
               phase_in            = PH_FIRST;
               result_valid        = 1'b1;
               result.frame_opcode = stream_byte[3:0];
               result.bad_header   = 1'b1;
            end
         end
      endcase

      if (length_done && mask_present_in) begin
         header_index_in = wsfd_pkg::KEY_BYTES;
         mask_key_in     = '0;
         phase_in        = PH_MASK;
      end else if (length_done || header_done) begin
         if (payload_length_in == '0) begin
            phase_in             = PH_FIRST;
            result_valid         = 1'b1;
            result.last_of_frame = 1'b1;
            result.frame_opcode  = opcode_held_ff;
            result.is_close      = close_held_ff;
         end else begin
            payload_index_in = '0;
            phase_in         = PH_PAYLOAD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_FIRST;
         header_index_ff   <= '0;
         payload_length_ff <= '0;
         payload_index_ff  <= '0;
         mask_key_ff       <= '0;
         mask_present_ff   <= 1'b0;
         opcode_held_ff    <= '0;
         close_held_ff     <= 1'b0;
      end else if (step) begin
         phase_ff          <= phase_in;
         header_index_ff   <= header_index_in;
         payload_length_ff <= payload_length_in;
         payload_index_ff  <= payload_index_in;
         mask_key_ff       <= mask_key_in;
         mask_present_ff   <= mask_present_in;
         opcode_held_ff    <= opcode_held_in;
         close_held_ff     <= close_held_in;
      end
   end

endmodule

@@ rtl/wsfd_out_reg.sv @@
`timescale 1ns / 1ps

module wsfd_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  wsfd_pkg::result_type in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output wsfd_pkg::result_type out_data
);

   logic                 valid_ff, valid_in;
   wsfd_pkg::result_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_valid || (valid_ff && !out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule

@@ rtl/websocket_frame_unmask_decoder.sv @@
// An accepted byte is held in the input register, then its result, if any, enters the result register.
// Throughput: one stream byte per cycle while rsp_ready stays high.
// A result that waits for rsp_ready stalls the input register; once it holds a byte, req_ready drops.
// The input register, the frame state update and the result register form the only path.
// Reset is synchronous and active high; it returns the parser to the start of a frame.
`timescale 1ns / 1ps

module websocket_frame_unmask_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last_of_frame,
   output logic [3:0] rsp_frame_opcode,
   output logic       rsp_is_close,
   output logic       rsp_bad_header
);

   logic                 in_valid_ff;
   logic [7:0]           in_byte_ff;
   logic                 out_ready;
   logic                 step;
   logic                 result_valid;
   wsfd_pkg::result_type result;
   wsfd_pkg::result_type rsp_data;

   assign step      = in_valid_ff && out_ready;
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   wsfd_frame_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .stream_byte  (in_byte_ff),
      .result_valid (result_valid),
      .result       (result)
   );

   wsfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step && result_valid),
      .in_ready  (out_ready),
      .in_data   (result),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_payload_byte  = rsp_data.payload_byte;
   assign rsp_has_byte      = rsp_data.has_byte;
   assign rsp_last_of_frame = rsp_data.last_of_frame;
   assign rsp_frame_opcode  = rsp_data.frame_opcode;
   assign rsp_is_close      = rsp_data.is_close;
   assign rsp_bad_header    = rsp_data.bad_header;

endmodule
